>>> hdl/sfd_pkg.sv
// Shared types, constants and the seven-segment table for the sensor frame decoder.
// No dependencies; every other file of the block refers to it by scoped names.
package sfd_pkg;

   // Frame layout
   localparam int FRAME_BYTES = 9;
   localparam int CNT_W       = 4;
   localparam logic [CNT_W-1:0] LAST_BYTE     = CNT_W'(FRAME_BYTES - 1);
   localparam logic [CNT_W-1:0] CMD_BYTE      = CNT_W'(1);
   localparam logic [CNT_W-1:0] SUM_LAST_BYTE = CNT_W'(5);
   localparam int STORE_FIRST = 2;
   localparam int STORE_LAST  = 7;

   // Field widths
   localparam int BYTE_W   = 8;
   localparam int CMD_W    = 8;
   localparam int FINE_W   = 14;
   localparam int COARSE_W = 16;
   localparam int SEG_W    = 8;
   localparam int DIGITS   = 4;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_EXPECTED_COMMAND = 2'd0,
      REG_FINE_LIMIT       = 2'd1,
      REG_COARSE_LIMIT     = 2'd2
   } reg_index_type;

   localparam logic [CMD_W-1:0]    RESET_EXPECTED_COMMAND = 8'h02;
   localparam logic [FINE_W-1:0]   RESET_FINE_LIMIT       = 14'd999;
   localparam logic [COARSE_W-1:0] RESET_COARSE_LIMIT     = 16'd1500;

   // Divide by ten: q = (v * DIV10_MUL) >> DIV10_SHIFT, exact for v below 2**16
   localparam int DIV10_MUL_W = 16;
   localparam logic [DIV10_MUL_W-1:0] DIV10_MUL = 16'd52429;
   localparam int DIV10_SHIFT = 19;
   localparam int PROD_W      = FINE_W + DIV10_MUL_W;
   localparam int QUOT_W      = PROD_W - DIV10_SHIFT;

   localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

   typedef struct packed {
      logic [CMD_W-1:0]    expected_command;
      logic [FINE_W-1:0]   fine_limit;
      logic [COARSE_W-1:0] coarse_limit;
   } cfg_type;

   typedef struct packed {
      logic                sum_ok;
      logic                command_ok;
      logic [FINE_W-1:0]   fine_value;
      logic [COARSE_W-1:0] coarse_value;
   } frame_rec_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic last_byte;
   } front_status_type;

   // Common-anode pattern for one decimal digit, active low
   function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
      logic [SEG_W-1:0] pattern;
      unique case (digit)
         4'd0:    pattern = 8'hC0;
         4'd1:    pattern = 8'hF9;
         4'd2:    pattern = 8'hA4;
         4'd3:    pattern = 8'hB0;
         4'd4:    pattern = 8'h99;
         4'd5:    pattern = 8'h92;
         4'd6:    pattern = 8'h82;
         4'd7:    pattern = 8'hF8;
         4'd8:    pattern = 8'h80;
         4'd9:    pattern = 8'h90;
         default: pattern = SEG_BLANK;
      endcase
      return pattern;
   endfunction

endpackage

>>> hdl/sfd_if.sv
// Valid/ready channel interfaces for byte input, frame results and register writes.
// Depends on sfd_pkg for field widths.
interface sfd_req_if;
   logic                         valid;
   logic                         ready;
   logic [sfd_pkg::BYTE_W-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          sum_ok;
   logic                          command_ok;
   logic [sfd_pkg::FINE_W-1:0]    fine_value;
   logic [sfd_pkg::COARSE_W-1:0]  coarse_value;
   logic [sfd_pkg::SEG_W-1:0]     seg_ones;
   logic [sfd_pkg::SEG_W-1:0]     seg_tens;
   logic [sfd_pkg::SEG_W-1:0]     seg_hundreds;
   logic [sfd_pkg::SEG_W-1:0]     seg_thousands;

   modport source (output valid, output sum_ok, output command_ok, output fine_value,
                   output coarse_value, output seg_ones, output seg_tens,
                   output seg_hundreds, output seg_thousands, input ready);
   modport sink   (input valid, input sum_ok, input command_ok, input fine_value,
                   input coarse_value, input seg_ones, input seg_tens,
                   input seg_hundreds, input seg_thousands, output ready);
endinterface

interface sfd_csr_if;
   logic                            valid;
   logic                            ready;
   logic [sfd_pkg::CSR_IDX_W-1:0]   index;
   logic [sfd_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/sensor_frame_decoder_unit.sv
// Top level of the sensor frame decoder: configuration registers, front end, record
// queue and back end. Depends on sfd_pkg, sfd_if, sfd_front, sfd_queue, sfd_back.
//
//  channel    dir  handshake            payload
//  req_chan   in   valid/ready          rx_byte[7:0]
//  rsp_chan   out  valid/ready          sum_ok, command_ok, fine_value, coarse_value, seg_*
//  csr_chan   in   valid/ready (ready=1) index[1:0], data[15:0]
//
// One byte is taken per cycle while ready is high; the ninth byte of a frame completes it.
// The back end works through a frame in steps (load, four divide-by-ten steps, commit)
// on its single digit unit. A stalled result register stalls only the back end; the queue
// of QUEUE_DEPTH records stalls the input only on a closing byte when it is full.
// Synchronous reset restores register defaults and blanks the display; no clearing pass.
module sensor_frame_decoder_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic       clock,
   input  logic       reset,
   sfd_req_if.sink    req_chan,
   sfd_rsp_if.source  rsp_chan,
   sfd_csr_if.sink    csr_chan
);

   sfd_pkg::cfg_type           cfg_ff;
   sfd_pkg::queue_status_type  q_stat;
   sfd_pkg::front_status_type  f_stat;
   sfd_pkg::frame_rec_type     push_rec;
   sfd_pkg::frame_rec_type     pop_rec;
   logic                       push;
   logic                       pop;

   // Register writes; unknown indexes drop
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_command <= sfd_pkg::RESET_EXPECTED_COMMAND;
         cfg_ff.fine_limit       <= sfd_pkg::RESET_FINE_LIMIT;
         cfg_ff.coarse_limit     <= sfd_pkg::RESET_COARSE_LIMIT;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            sfd_pkg::REG_EXPECTED_COMMAND:
               cfg_ff.expected_command <= csr_chan.data[sfd_pkg::CMD_W-1:0];
            sfd_pkg::REG_FINE_LIMIT:
               cfg_ff.fine_limit <= csr_chan.data[sfd_pkg::FINE_W-1:0];
            sfd_pkg::REG_COARSE_LIMIT:
               cfg_ff.coarse_limit <= csr_chan.data[sfd_pkg::COARSE_W-1:0];
            default: ;
         endcase
      end
   end

   sfd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .cfg      (cfg_ff),
      .q_stat   (q_stat),
      .push     (push),
      .push_rec (push_rec),
      .f_stat   (f_stat)
   );

   sfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_stat   (q_stat)
   );

   sfd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_stat   (q_stat),
      .pop_rec  (pop_rec),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // Never push a finished frame into a full queue
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && f_stat.last_byte) |-> !q_stat.full)
      else $error("frame record pushed into full queue");

   // Queue fill level stays consistent
   a_queue_level: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.empty && q_stat.full))
      else $error("queue reports empty and full together");

   // Readings on a pending result respect the clamp limits
   a_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.fine_value <= cfg_ff.fine_limit &&
                          rsp_chan.coarse_value <= cfg_ff.coarse_limit))
      else $error("result reading exceeds its limit");

endmodule

>>> hdl/sfd_front.sv
// Front end: takes bytes, bit-reverses them, gathers a frame and forms the checked record.
// Depends on sfd_pkg and sfd_if.
module sfd_front (
   input  logic                       clock,
   input  logic                       reset,
   sfd_req_if.sink                    req_chan,
   input  sfd_pkg::cfg_type           cfg,
   input  sfd_pkg::queue_status_type  q_stat,
   output logic                       push,
   output sfd_pkg::frame_rec_type     push_rec,
   output sfd_pkg::front_status_type  f_stat
);

   logic [sfd_pkg::CNT_W-1:0]   count_ff;
   logic [15:0]                 sum_ff;
   logic                        cmd_ok_ff;
   logic [sfd_pkg::BYTE_W-1:0]  frame_ff [sfd_pkg::STORE_FIRST:sfd_pkg::STORE_LAST];

   logic [sfd_pkg::BYTE_W-1:0]  rev;
   logic                        accept;
   logic                        last;
   logic [15:0]                 sum_total;
   logic [15:0]                 fine_raw;
   logic [15:0]                 coarse_raw;

   // Mirror the received byte
   always_comb begin
      for (int i = 0; i < sfd_pkg::BYTE_W; i++) begin
         rev[i] = req_chan.rx_byte[sfd_pkg::BYTE_W-1-i];
      end
   end

   // Stall only the closing byte while the queue has no room
   assign last           = (count_ff == sfd_pkg::LAST_BYTE);
   assign req_chan.ready = !(last && q_stat.full);
   assign accept         = req_chan.valid && req_chan.ready;
   assign f_stat.last_byte = last;

   // Gather the frame
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= last ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (count_ff == '0) begin
            sum_ff <= {8'd0, rev};
         end else if (count_ff <= sfd_pkg::SUM_LAST_BYTE) begin
            sum_ff <= sum_ff + {8'd0, rev};
         end
         if (count_ff == sfd_pkg::CMD_BYTE) begin
            cmd_ok_ff <= (rev == cfg.expected_command);
         end
         if (count_ff >= sfd_pkg::CNT_W'(sfd_pkg::STORE_FIRST) &&
             count_ff <= sfd_pkg::CNT_W'(sfd_pkg::STORE_LAST)) begin
            frame_ff[count_ff[2:0]] <= rev;
         end
      end
   end

   // Check and clamp on the closing byte
   always_comb begin
      sum_total  = sum_ff + {8'd0, rev};
      fine_raw   = {frame_ff[4], frame_ff[5]};
      coarse_raw = {frame_ff[2], frame_ff[3]};
      push_rec.sum_ok     = (sum_total == {frame_ff[6], frame_ff[7]});
      push_rec.command_ok = cmd_ok_ff;
      if (fine_raw > {2'b00, cfg.fine_limit}) begin
         push_rec.fine_value = cfg.fine_limit;
      end else begin
         push_rec.fine_value = fine_raw[sfd_pkg::FINE_W-1:0];
      end
      if (coarse_raw > cfg.coarse_limit) begin
         push_rec.coarse_value = cfg.coarse_limit;
      end else begin
         push_rec.coarse_value = coarse_raw;
      end
   end

   assign push = accept && last;

endmodule

>>> hdl/sfd_queue.sv
// Small FIFO of checked frame records between front and back end.
// Depends on sfd_pkg.
module sfd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  sfd_pkg::frame_rec_type     push_rec,
   input  logic                       pop,
   output sfd_pkg::frame_rec_type     pop_rec,
   output sfd_pkg::queue_status_type  q_stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sfd_pkg::frame_rec_type  entry_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [CNT_W-1:0]        count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == CNT_FULL);
   assign do_push = push && !q_stat.full;
   assign do_pop  = pop && !q_stat.empty;
   assign pop_rec = entry_ff[rd_ptr_ff];

   // Store records
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> hdl/sfd_back.sv
// Back end: splits the fine reading into decimal digits, updates the held display when sum
// and command are good, and drives the result register. Depends on sfd_pkg and sfd_if.
module sfd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  sfd_pkg::queue_status_type  q_stat,
   input  sfd_pkg::frame_rec_type     pop_rec,
   output logic                       pop,
   sfd_rsp_if.source                  rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_DONE
   } state_type;

   state_type                    state_ff;
   sfd_pkg::frame_rec_type       rec_ff;
   logic [sfd_pkg::FINE_W-1:0]   val_ff;
   logic [1:0]                   step_ff;
   logic [sfd_pkg::SEG_W-1:0]    segs_ff    [sfd_pkg::DIGITS];
   logic [sfd_pkg::SEG_W-1:0]    display_ff [sfd_pkg::DIGITS];
   logic                         out_valid_ff;
   sfd_pkg::frame_rec_type       out_rec_ff;
   logic [sfd_pkg::SEG_W-1:0]    out_seg_ff [sfd_pkg::DIGITS];

   logic [sfd_pkg::PROD_W-1:0]   prod;
   logic [sfd_pkg::QUOT_W-1:0]   quot;
   logic [sfd_pkg::FINE_W-1:0]   quot_x10;
   logic [3:0]                   digit;
   logic                         out_free;
   logic                         update;

   // One decimal digit per cycle: divide by ten through a reciprocal multiply
   always_comb begin
      prod     = val_ff * sfd_pkg::PROD_W'(sfd_pkg::DIV10_MUL);
      quot     = prod[sfd_pkg::PROD_W-1:sfd_pkg::DIV10_SHIFT];
      quot_x10 = sfd_pkg::FINE_W'({quot, 3'b000}) + sfd_pkg::FINE_W'({quot, 1'b0});
      digit    = 4'(val_ff - quot_x10);
   end

   assign out_free = !out_valid_ff || rsp_chan.ready;
   assign pop      = (state_ff == S_IDLE) && !q_stat.empty;
   assign update   = rec_ff.sum_ok && rec_ff.command_ok;

   // Sequence one record: load, four digit steps, commit
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < sfd_pkg::DIGITS; i++) begin
            display_ff[i] <= sfd_pkg::SEG_BLANK;
         end
      end else begin
         if (out_valid_ff && rsp_chan.ready && state_ff != S_DONE) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  rec_ff   <= pop_rec;
                  val_ff   <= pop_rec.fine_value;
                  step_ff  <= '0;
                  state_ff <= S_CONV;
               end
            end
            S_CONV: begin
               segs_ff[step_ff] <= sfd_pkg::seg_of(digit);
               val_ff           <= sfd_pkg::FINE_W'(quot);
               step_ff          <= step_ff + 1'b1;
               if (step_ff == 2'(sfd_pkg::DIGITS - 1)) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_rec_ff   <= rec_ff;
                  for (int i = 0; i < sfd_pkg::DIGITS; i++) begin
                     if (update) begin
                        display_ff[i] <= segs_ff[i];
                        out_seg_ff[i] <= segs_ff[i];
                     end else begin
                        out_seg_ff[i] <= display_ff[i];
                     end
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Drive the result channel from the output register
   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.sum_ok        = out_rec_ff.sum_ok;
   assign rsp_chan.command_ok    = out_rec_ff.command_ok;
   assign rsp_chan.fine_value    = out_rec_ff.fine_value;
   assign rsp_chan.coarse_value  = out_rec_ff.coarse_value;
   assign rsp_chan.seg_ones      = out_seg_ff[0];
   assign rsp_chan.seg_tens      = out_seg_ff[1];
   assign rsp_chan.seg_hundreds  = out_seg_ff[2];
   assign rsp_chan.seg_thousands = out_seg_ff[3];

endmodule

>>> tb/sv/sensor_frame_decoder_unit_tb.sv
// Testbench for sensor_frame_decoder_unit: sends byte frames with random gaps and result
// stalls, writes registers, predicts every frame result and checks it in order.
// Depends on sfd_pkg, the channel interfaces in sfd_if and the block's RTL.
module sensor_frame_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int MAX_REPORTS      = 10;
   localparam int RANDOM_PHASES    = 12;
   localparam int FRAMES_PER_PHASE = 10;
   localparam int SETTLE_CYCLES    = 12;
   localparam logic [sfd_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   // Common-anode glyphs, digit 0 in the lowest slot
   localparam logic [9:0][sfd_pkg::SEG_W-1:0] DIGIT_GLYPH = {
      8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
   };

   typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_BAD_CMD, FRAME_NOISE} frame_kind_type;

   typedef struct packed {
      logic                         sum_ok;
      logic                         command_ok;
      logic [sfd_pkg::FINE_W-1:0]   fine_value;
      logic [sfd_pkg::COARSE_W-1:0] coarse_value;
      logic [sfd_pkg::SEG_W-1:0]    seg_ones;
      logic [sfd_pkg::SEG_W-1:0]    seg_tens;
      logic [sfd_pkg::SEG_W-1:0]    seg_hundreds;
      logic [sfd_pkg::SEG_W-1:0]    seg_thousands;
   } frame_result_type;

   // Swap bit order: bit 0 becomes bit 7
   function automatic logic [sfd_pkg::BYTE_W-1:0] mirror_byte(
         input logic [sfd_pkg::BYTE_W-1:0] b);
      logic [sfd_pkg::BYTE_W-1:0] r;
      for (int i = 0; i < sfd_pkg::BYTE_W; i++) r[i] = b[sfd_pkg::BYTE_W-1-i];
      return r;
   endfunction

   // Decoder model: gathers bytes into frames and queues the frame results it predicts
   class frame_checker;
      logic [sfd_pkg::CMD_W-1:0]    expected_command;
      logic [sfd_pkg::FINE_W-1:0]   fine_limit;
      logic [sfd_pkg::COARSE_W-1:0] coarse_limit;
      logic [sfd_pkg::BYTE_W-1:0]   frame_store [sfd_pkg::FRAME_BYTES];
      int                           byte_count;
      logic [sfd_pkg::SEG_W-1:0]    glyphs [sfd_pkg::DIGITS];
      frame_result_type             pending_frames [$];
      int                           failures;

      function new();
         expected_command = sfd_pkg::RESET_EXPECTED_COMMAND;
         fine_limit       = sfd_pkg::RESET_FINE_LIMIT;
         coarse_limit     = sfd_pkg::RESET_COARSE_LIMIT;
         byte_count       = 0;
         failures         = 0;
         foreach (glyphs[i]) glyphs[i] = sfd_pkg::SEG_BLANK;
         foreach (frame_store[i]) frame_store[i] = '0;
      endfunction

      function void note_register(input logic [sfd_pkg::CSR_IDX_W-1:0] index,
                                  input logic [sfd_pkg::CSR_DATA_W-1:0] data);
         unique case (index)
            sfd_pkg::REG_EXPECTED_COMMAND:
               expected_command = data[sfd_pkg::CMD_W-1:0];
            sfd_pkg::REG_FINE_LIMIT:
               fine_limit = data[sfd_pkg::FINE_W-1:0];
            sfd_pkg::REG_COARSE_LIMIT:
               coarse_limit = data[sfd_pkg::COARSE_W-1:0];
            default: ;
         endcase
      endfunction

      function void absorb_byte(input logic [sfd_pkg::BYTE_W-1:0] raw);
         logic [15:0]      sum;
         int               fine;
         int               coarse;
         frame_result_type res;
         if (byte_count >= sfd_pkg::FRAME_BYTES) byte_count = 0;
         frame_store[byte_count] = mirror_byte(raw);
         byte_count++;
         if (byte_count < sfd_pkg::FRAME_BYTES) return;
         byte_count = 0;

         // Checksum over bytes 0..5 and 8, wrapped to 16 bits
         sum = '0;
         for (int n = 0; n <= 5; n++) sum = sum + frame_store[n];
         sum = sum + frame_store[8];
         res.sum_ok     = (sum == {frame_store[6], frame_store[7]});
         res.command_ok = (frame_store[1] == expected_command);

         // Clamp both readings
         fine = {frame_store[4], frame_store[5]};
         if (fine > fine_limit) fine = fine_limit;
         coarse = {frame_store[2], frame_store[3]};
         if (coarse > coarse_limit) coarse = coarse_limit;
         res.fine_value   = sfd_pkg::FINE_W'(fine);
         res.coarse_value = sfd_pkg::COARSE_W'(coarse);

         // Refresh the held display only on a fully valid frame
         if (res.sum_ok && res.command_ok) begin
            glyphs[0] = DIGIT_GLYPH[fine % 10];
            glyphs[1] = DIGIT_GLYPH[(fine / 10) % 10];
            glyphs[2] = DIGIT_GLYPH[(fine / 100) % 10];
            glyphs[3] = DIGIT_GLYPH[(fine / 1000) % 10];
         end
         res.seg_ones      = glyphs[0];
         res.seg_tens      = glyphs[1];
         res.seg_hundreds  = glyphs[2];
         res.seg_thousands = glyphs[3];
         pending_frames.push_back(res);
      endfunction

      function string describe(input frame_result_type r);
         return $sformatf("sum_ok=%0b command_ok=%0b fine=%0d coarse=%0d seg=%h_%h_%h_%h",
                          r.sum_ok, r.command_ok, r.fine_value, r.coarse_value,
                          r.seg_thousands, r.seg_hundreds, r.seg_tens, r.seg_ones);
      endfunction

      function void check_frame(input frame_result_type got);
         frame_result_type want;
         if (pending_frames.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("result with no frame pending: %s", describe(got));
            return;
         end
         want = pending_frames.pop_front();
         if (got.sum_ok !== want.sum_ok || got.command_ok !== want.command_ok ||
             got.fine_value !== want.fine_value || got.coarse_value !== want.coarse_value ||
             got.seg_ones !== want.seg_ones || got.seg_tens !== want.seg_tens ||
             got.seg_hundreds !== want.seg_hundreds ||
             got.seg_thousands !== want.seg_thousands) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("frame mismatch: expected %s, actual %s", describe(want),
                        describe(got));
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   int   cycle_count = 0;
   int   req_burst = 0;
   int   rsp_burst = 0;
   int   rsp_stall = 0;

   frame_checker decoder_model;

   sfd_req_if req_bus ();
   sfd_rsp_if rsp_bus ();
   sfd_csr_if csr_bus ();

   sensor_frame_decoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly no gap, some short ones, a few long, and gap-free bursts
   function automatic int pick_gap(inout int burst);
      int roll;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         burst = $urandom_range(10, 40);
         return 0;
      end
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Reading below or near the limit, or random over the whole 16-bit range
   function automatic logic [15:0] pick_reading(input int limit);
      int roll;
      int v;
      roll = $urandom_range(0, 9);
      if (roll < 5) return 16'($urandom_range(0, limit));
      if (roll < 7) begin
         v = limit + $urandom_range(0, 6) - 3;
         if (v < 0) v = 0;
         if (v > 65535) v = 65535;
         return 16'(v);
      end
      return 16'($urandom);
   endfunction

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check accepted results, then pick the next stall
   always @(posedge clock) begin : result_side
      frame_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.sum_ok        = rsp_bus.sum_ok;
         got.command_ok    = rsp_bus.command_ok;
         got.fine_value    = rsp_bus.fine_value;
         got.coarse_value  = rsp_bus.coarse_value;
         got.seg_ones      = rsp_bus.seg_ones;
         got.seg_tens      = rsp_bus.seg_tens;
         got.seg_hundreds  = rsp_bus.seg_hundreds;
         got.seg_thousands = rsp_bus.seg_thousands;
         decoder_model.check_frame(got);
      end
      if (rsp_stall > 0) begin
         rsp_bus.ready <= 1'b0;
         rsp_stall--;
      end else begin
         rsp_stall = pick_gap(rsp_burst);
         rsp_bus.ready <= (rsp_stall == 0);
      end
   end

   task automatic send_byte(input logic [sfd_pkg::BYTE_W-1:0] value);
      int gap;
      gap = pick_gap(req_burst);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= value;
      do @(posedge clock); while (!req_bus.ready);
      decoder_model.absorb_byte(value);
   endtask

   // Build a frame in decoded order, corrupt it as asked, send it bit-reversed
   task automatic send_frame(input frame_kind_type kind,
                             input logic [sfd_pkg::CMD_W-1:0] cmd,
                             input logic [15:0] fine_raw, input logic [15:0] coarse_raw,
                             input logic [sfd_pkg::BYTE_W-1:0] lead,
                             input logic [sfd_pkg::BYTE_W-1:0] tail);
      logic [sfd_pkg::BYTE_W-1:0] fb [sfd_pkg::FRAME_BYTES];
      logic [15:0]                sum;
      int                         pos;
      fb[0] = lead;
      fb[1] = cmd;
      {fb[2], fb[3]} = coarse_raw;
      {fb[4], fb[5]} = fine_raw;
      fb[8] = tail;
      sum = '0;
      for (int n = 0; n <= 5; n++) sum = sum + fb[n];
      sum = sum + fb[8];
      {fb[6], fb[7]} = sum;
      unique case (kind)
         FRAME_BAD_SUM: begin
            pos = 6 + $urandom_range(0, 1);
            fb[pos] = fb[pos] ^ 8'($urandom_range(1, 255));
         end
         FRAME_BAD_CMD: fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
         FRAME_NOISE: foreach (fb[i]) fb[i] = 8'($urandom);
         default: ;
      endcase
      foreach (fb[i]) send_byte(mirror_byte(fb[i]));
   endtask

   // Write all registers back to back, optionally poke the unmapped index
   task automatic write_settings(input logic [sfd_pkg::CSR_DATA_W-1:0] cmd_data,
                                 input logic [sfd_pkg::CSR_DATA_W-1:0] fine_data,
                                 input logic [sfd_pkg::CSR_DATA_W-1:0] coarse_data,
                                 input bit poke_unused);
      logic [sfd_pkg::CSR_IDX_W-1:0]  idx [4];
      logic [sfd_pkg::CSR_DATA_W-1:0] val [4];
      int                             count;
      idx[0] = sfd_pkg::REG_EXPECTED_COMMAND;
      val[0] = cmd_data;
      idx[1] = sfd_pkg::REG_FINE_LIMIT;
      val[1] = fine_data;
      idx[2] = sfd_pkg::REG_COARSE_LIMIT;
      val[2] = coarse_data;
      idx[3] = REG_UNUSED;
      val[3] = 16'($urandom);
      count  = poke_unused ? 4 : 3;
      for (int k = 0; k < count; k++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= idx[k];
         csr_bus.data  <= val[k];
         do @(posedge clock); while (!csr_bus.ready);
         decoder_model.note_register(idx[k], val[k]);
      end
      csr_bus.valid <= 1'b0;
   endtask

   // Drop valid, let every pending frame drain, then let the back end settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (decoder_model.pending_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin : stimulus
      int roll;
      frame_kind_type kind;
      decoder_model = new();
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.rx_byte <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: valid frame at reset settings, all-zero frame with wrong command
      send_frame(FRAME_GOOD, sfd_pkg::RESET_EXPECTED_COMMAND, 16'd123, 16'd1000,
                 8'h00, 8'h00);
      send_frame(FRAME_GOOD, 8'h00, 16'h0000, 16'h0000, 8'h00, 8'h00);
      wait_idle();
      // Directed: widest limits, fine reading above 9999, junk upper data bits
      write_settings(16'hA5FF, 16'hFFFF, 16'hFFFF, 1'b1);
      send_frame(FRAME_GOOD, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
      wait_idle();

      // Random phases, extremes of the settings first
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         unique case (p)
            0: write_settings(16'h0000, 16'h0000, 16'h0000, 1'b1);
            1: write_settings(16'h00FF, 16'd9999, 16'hFFFF, 1'b0);
            2: write_settings(16'(sfd_pkg::RESET_EXPECTED_COMMAND),
                              16'(sfd_pkg::RESET_FINE_LIMIT),
                              16'(sfd_pkg::RESET_COARSE_LIMIT), 1'b0);
            3: write_settings(16'($urandom), 16'h3FFF, 16'($urandom), 1'b1);
            default: write_settings(16'($urandom),
                                    16'($urandom_range(0, 9999)) |
                                    (16'($urandom_range(0, 3)) << sfd_pkg::FINE_W),
                                    16'($urandom), 1'($urandom_range(0, 1)));
         endcase
         for (int f = 0; f < FRAMES_PER_PHASE; f++) begin
            roll = $urandom_range(0, 9);
            if (roll < 7)       kind = FRAME_GOOD;
            else if (roll == 7) kind = FRAME_BAD_SUM;
            else if (roll == 8) kind = FRAME_BAD_CMD;
            else                kind = FRAME_NOISE;
            send_frame(kind, decoder_model.expected_command,
                       pick_reading(decoder_model.fine_limit),
                       pick_reading(decoder_model.coarse_limit),
                       8'($urandom), 8'($urandom));
         end
         wait_idle();
      end

      if (decoder_model.failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/sfd_pkg.sv
hdl/sfd_if.sv
hdl/sfd_front.sv
hdl/sfd_queue.sv
hdl/sfd_back.sv
hdl/sensor_frame_decoder_unit.sv
tb/sv/sensor_frame_decoder_unit_tb.sv
